### hdl/dxt_pkg.sv
package dxt_pkg;

  localparam int unsigned DXT_MAX_IMAGE_DIM = 4096;
  localparam int unsigned DXT_QUEUE_DEPTH   = 2;
  localparam int unsigned DXT_CFG_W         = 13;
  localparam int unsigned DXT_CFG_IDX_W     = 2;

  localparam logic [DXT_CFG_IDX_W-1:0] REG_HAS_ALPHA    = 2'd0;
  localparam logic [DXT_CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [DXT_CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // One decoded block waiting for texel emission.
  typedef struct packed {
    logic [3:0][23:0] color;
    logic [7:0][7:0]  alpha;
    logic [31:0]      color_codes;
    logic [47:0]      alpha_codes;
    logic [9:0]       blk_x;
    logic [9:0]       blk_y;
    logic [1:0]       cols_m1;
    logic [1:0]       rows_m1;
  } dxt_entry_t;

  function automatic logic [7:0] widen5(logic [4:0] v);
    logic [12:0] t;
    logic [13:0] s;
    t = 13'({8'd0, v} * 13'd255) + 13'd16;
    s = {1'b0, t} + 14'(t >> 5);
    return 8'(s >> 5);
  endfunction

  function automatic logic [7:0] widen6(logic [5:0] v);
    logic [13:0] t;
    logic [14:0] s;
    t = 14'({8'd0, v} * 14'd255) + 14'd32;
    s = {1'b0, t} + 15'(t >> 6);
    return 8'(s >> 6);
  endfunction

  // x / 3 for x < 768
  function automatic logic [7:0] div3(logic [9:0] x);
    logic [19:0] p;
    p = {10'd0, x} * 20'd683;
    return p[18:11];
  endfunction

  // x / 7 for x < 1792
  function automatic logic [7:0] div7(logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    return p[21:14];
  endfunction

  // x / 5 for x < 1280
  function automatic logic [7:0] div5(logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    return p[21:14];
  endfunction

  function automatic logic [7:0] mix3(logic [7:0] a, logic [7:0] b);
    return div3({1'b0, a, 1'b0} + {2'b0, b});
  endfunction

  function automatic logic [7:0] avg2(logic [7:0] a, logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[8:1];
  endfunction

endpackage

### hdl/dxt_front.sv
module dxt_front import dxt_pkg::*; #(
  parameter int unsigned MAX_IMAGE_DIM = DXT_MAX_IMAGE_DIM
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [DXT_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DXT_CFG_W-1:0]     cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               alpha_end0_i,
  input  logic [7:0]               alpha_end1_i,
  input  logic [47:0]              alpha_codes_i,
  input  logic [15:0]              color_end0_i,
  input  logic [15:0]              color_end1_i,
  input  logic [31:0]              color_codes_i,
  output logic                     q_push_o,
  output dxt_entry_t               q_entry_o,
  input  logic                     q_full_i
);

  localparam int unsigned DIM_W = $clog2(MAX_IMAGE_DIM + 1);
  localparam int unsigned CNT_W = DIM_W - 1;

  function automatic logic [DIM_W-1:0] eff_dim(logic [DXT_CFG_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (32'(v) > 32'(MAX_IMAGE_DIM)) return DIM_W'(MAX_IMAGE_DIM);
    return DIM_W'(v);
  endfunction

  function automatic logic [CNT_W-1:0] blocks(logic [DIM_W-1:0] d);
    logic [DIM_W:0] s;
    s = {1'b0, d} + (DIM_W+1)'(3);
    return CNT_W'(s >> 2);
  endfunction

  // config and block position
  logic             has_alpha_q, has_alpha_d;
  logic [DIM_W-1:0] w_q, w_d, h_q, h_d;
  logic [CNT_W-1:0] bx_q, bx_d, by_q, by_d;
  logic [CNT_W-1:0] col_q, col_d, row_q, row_d;

  // registered block
  logic             f1_valid_q, f1_valid_d;
  logic [1:0][7:0]  r_q, g_q, b_q;
  logic [7:0]       a0_q, a1_q;
  logic [47:0]      acodes_q;
  logic [31:0]      ccodes_q;
  logic             four_q;
  logic [9:0]       blk_x_q, blk_y_q;
  logic [1:0]       cols_m1_q, rows_m1_q;

  logic             accept;
  logic [CNT_W-1:0] col_e, row_e;
  logic [CNT_W:0]   col_n, row_n;
  logic [DIM_W:0]   rem_x, rem_y;
  logic [1:0]       cols_m1, rows_m1;

  assign full     = f1_valid_q & q_full_i;
  assign accept   = push & ~full;
  assign q_push_o = f1_valid_q & ~q_full_i;

  assign col_e = (col_q >= bx_q) ? '0 : col_q;
  assign row_e = (row_q >= by_q) ? '0 : row_q;
  assign col_n = {1'b0, col_e} + (CNT_W+1)'(1);
  assign row_n = {1'b0, row_e} + (CNT_W+1)'(1);

  // visible texels of this block, at least one in each direction
  assign rem_x   = {1'b0, w_q} - {col_e, 2'b00};
  assign rem_y   = {1'b0, h_q} - {row_e, 2'b00};
  assign cols_m1 = (rem_x >= (DIM_W+1)'(4)) ? 2'd3 : rem_x[1:0] - 2'd1;
  assign rows_m1 = (rem_y >= (DIM_W+1)'(4)) ? 2'd3 : rem_y[1:0] - 2'd1;

  always_comb begin
    has_alpha_d = has_alpha_q;
    w_d         = w_q;
    h_d         = h_q;
    bx_d        = bx_q;
    by_d        = by_q;
    col_d       = col_q;
    row_d       = row_q;
    f1_valid_d  = accept | (f1_valid_q & q_full_i);
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_HAS_ALPHA: begin
          has_alpha_d = cfg_wdata_i[0];
          col_d       = '0;
          row_d       = '0;
        end
        REG_IMAGE_WIDTH: begin
          w_d   = eff_dim(cfg_wdata_i);
          bx_d  = blocks(eff_dim(cfg_wdata_i));
          col_d = '0;
          row_d = '0;
        end
        REG_IMAGE_HEIGHT: begin
          h_d   = eff_dim(cfg_wdata_i);
          by_d  = blocks(eff_dim(cfg_wdata_i));
          col_d = '0;
          row_d = '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (col_n >= {1'b0, bx_q}) begin
        col_d = '0;
        row_d = (row_n >= {1'b0, by_q}) ? '0 : row_n[CNT_W-1:0];
      end else begin
        col_d = col_n[CNT_W-1:0];
        row_d = row_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      has_alpha_q <= 1'b0;
      w_q         <= DIM_W'(4);
      h_q         <= DIM_W'(4);
      bx_q        <= CNT_W'(1);
      by_q        <= CNT_W'(1);
      col_q       <= '0;
      row_q       <= '0;
      f1_valid_q  <= 1'b0;
    end else begin
      has_alpha_q <= has_alpha_d;
      w_q         <= w_d;
      h_q         <= h_d;
      bx_q        <= bx_d;
      by_q        <= by_d;
      col_q       <= col_d;
      row_q       <= row_d;
      f1_valid_q  <= f1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q[0]    <= widen5(color_end0_i[15:11]);
      g_q[0]    <= widen6(color_end0_i[10:5]);
      b_q[0]    <= widen5(color_end0_i[4:0]);
      r_q[1]    <= widen5(color_end1_i[15:11]);
      g_q[1]    <= widen6(color_end1_i[10:5]);
      b_q[1]    <= widen5(color_end1_i[4:0]);
      a0_q      <= alpha_end0_i;
      a1_q      <= alpha_end1_i;
      acodes_q  <= alpha_codes_i;
      ccodes_q  <= color_codes_i;
      four_q    <= has_alpha_q | (color_end0_i > color_end1_i);
      blk_x_q   <= 10'(col_e);
      blk_y_q   <= 10'(row_e);
      cols_m1_q <= cols_m1;
      rows_m1_q <= rows_m1;
    end
  end

  // palettes
  always_comb begin
    q_entry_o.color[0] = {r_q[0], g_q[0], b_q[0]};
    q_entry_o.color[1] = {r_q[1], g_q[1], b_q[1]};
    if (four_q) begin
      q_entry_o.color[2] = {mix3(r_q[0], r_q[1]), mix3(g_q[0], g_q[1]),
                            mix3(b_q[0], b_q[1])};
      q_entry_o.color[3] = {mix3(r_q[1], r_q[0]), mix3(g_q[1], g_q[0]),
                            mix3(b_q[1], b_q[0])};
    end else begin
      q_entry_o.color[2] = {avg2(r_q[0], r_q[1]), avg2(g_q[0], g_q[1]),
                            avg2(b_q[0], b_q[1])};
      q_entry_o.color[3] = '0;
    end
    q_entry_o.alpha[0] = has_alpha_q ? a0_q : 8'hff;
    q_entry_o.alpha[1] = has_alpha_q ? a1_q : 8'hff;
    for (int c = 2; c < 8; c++) begin
      if (!has_alpha_q) begin
        q_entry_o.alpha[c] = 8'hff;
      end else if (a0_q > a1_q) begin
        q_entry_o.alpha[c] = div7(11'((8 - c) * int'(a0_q) + (c - 1) * int'(a1_q)));
      end else if (c == 6) begin
        q_entry_o.alpha[c] = 8'h00;
      end else if (c == 7) begin
        q_entry_o.alpha[c] = 8'hff;
      end else begin
        q_entry_o.alpha[c] = div5(11'((6 - c) * int'(a0_q) + (c - 1) * int'(a1_q)));
      end
    end
    q_entry_o.color_codes = ccodes_q;
    q_entry_o.alpha_codes = acodes_q;
    q_entry_o.blk_x       = blk_x_q;
    q_entry_o.blk_y       = blk_y_q;
    q_entry_o.cols_m1     = cols_m1_q;
    q_entry_o.rows_m1     = rows_m1_q;
  end

endmodule

### hdl/dxt_queue.sv
module dxt_queue import dxt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  dxt_entry_t wdata_i,
  output logic       full_o,
  input  logic       pop_i,
  output dxt_entry_t rdata_o,
  output logic       empty_o
);

  localparam int unsigned PTR_W = (DXT_QUEUE_DEPTH > 1) ? $clog2(DXT_QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DXT_QUEUE_DEPTH + 1);

  dxt_entry_t       mem_q [DXT_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DXT_QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(DXT_QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(DXT_QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### hdl/dxt_back.sv
module dxt_back import dxt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  dxt_entry_t  q_entry_i,
  output logic        q_pop_o,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] texel_x_o,
  output logic [11:0] texel_y_o,
  output logic [31:0] rgba_o,
  output logic        last_of_block_o
);

  logic        out_valid_q, out_valid_d;
  logic [1:0]  i_q, i_d, j_q, j_d;
  logic [3:0]  t;
  logic [5:0]  aidx;
  logic [1:0]  cc;
  logic [2:0]  ac;
  logic        advance;
  logic        last;

  assign empty   = ~out_valid_q;
  assign advance = ~q_empty_i & (~out_valid_q | pop);
  assign last    = (i_q == q_entry_i.cols_m1) && (j_q == q_entry_i.rows_m1);
  assign q_pop_o = advance & last;

  assign t    = {j_q, i_q};
  assign aidx = {2'b00, t} + {1'b0, t, 1'b0};
  assign cc   = q_entry_i.color_codes[{t, 1'b0} +: 2];
  assign ac   = q_entry_i.alpha_codes[aidx +: 3];

  // walk only the visible part of the block, row-major
  always_comb begin
    out_valid_d = advance | (out_valid_q & ~pop);
    i_d         = i_q;
    j_d         = j_q;
    if (advance) begin
      if (last) begin
        i_d = '0;
        j_d = '0;
      end else if (i_q == q_entry_i.cols_m1) begin
        i_d = '0;
        j_d = j_q + 2'd1;
      end else begin
        i_d = i_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      i_q         <= i_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      texel_x_o       <= {q_entry_i.blk_x, i_q};
      texel_y_o       <= {q_entry_i.blk_y, j_q};
      rgba_o          <= {q_entry_i.color[cc], q_entry_i.alpha[ac]};
      last_of_block_o <= last;
    end
  end

endmodule

### hdl/dxt_block_decompressor.sv
// DXT1/DXT5 block decompressor.
// Input channel (push/full): one compressed 4x4 block per beat, blocks in
// raster order across the image. Output channel (empty/pop): one texel per
// beat with its image x/y, RGBA and a flag on the last texel of the block.
// Config port: cfg_we_i writes register cfg_index_i (0 has_alpha, 1 width,
// 2 height); any write of those returns the block position to the image
// origin. Write config only while the block is idle.
// Throughput: one texel per cycle while pop is not held low; a full block
// gives 16 texels, edge blocks clipped by width or height fewer. The texel
// sequencer in the back end sets this rate; palette decode runs ahead and
// up to two decoded blocks wait in the queue plus one in the input stage.
// A block's first texel passes the input-stage register, the queue and the
// output register on its way to the outputs when the back end is free.
// Reset: position at origin, width/height 4, DXT1 mode, all stages empty.
// When pop is held low the output register holds its beat, the queue fills,
// and full rises once the input stage is also occupied.
module dxt_block_decompressor import dxt_pkg::*; #(
  parameter int unsigned MAX_IMAGE_DIM = DXT_MAX_IMAGE_DIM
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [DXT_CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DXT_CFG_W-1:0]     cfg_wdata_i,
  input  logic                     push,
  output logic                     full,
  input  logic [7:0]               alpha_end0_i,
  input  logic [7:0]               alpha_end1_i,
  input  logic [47:0]              alpha_codes_i,
  input  logic [15:0]              color_end0_i,
  input  logic [15:0]              color_end1_i,
  input  logic [31:0]              color_codes_i,
  output logic                     empty,
  input  logic                     pop,
  output logic [11:0]              texel_x_o,
  output logic [11:0]              texel_y_o,
  output logic [31:0]              rgba_o,
  output logic                     last_of_block_o
);

  logic       q_push, q_pop, q_full, q_empty;
  dxt_entry_t q_wdata, q_rdata;

  dxt_front #(
    .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .alpha_end0_i (alpha_end0_i),
    .alpha_end1_i (alpha_end1_i),
    .alpha_codes_i(alpha_codes_i),
    .color_end0_i (color_end0_i),
    .color_end1_i (color_end1_i),
    .color_codes_i(color_codes_i),
    .q_push_o     (q_push),
    .q_entry_o    (q_wdata),
    .q_full_i     (q_full)
  );

  dxt_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  dxt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_entry_i      (q_rdata),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .texel_x_o      (texel_x_o),
    .texel_y_o      (texel_y_o),
    .rgba_o         (rgba_o),
    .last_of_block_o(last_of_block_o)
  );

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("decoded block pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_full_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> q_full)
    else $error("input stalled while the queue has room");

  a_pop_then_texel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |=> !empty && last_of_block_o)
    else $error("block retired without its last texel on the outputs");

endmodule
